// ----- design/assert_macros.svh -----
// Assertion macros used by the RTL of the SIRS Heun step block.
// Depends on nothing; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Invariant, checked at every edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  `ASSERT_IMPL(label, clk, rst_n, 1'b1, cond, msg)

`endif

// ----- design/sirs_pkg.sv -----
// Package for the SIRS Heun step block: widths, reset values, codes and
// the request/status structs of the shared multiplier. Depends on nothing.
`default_nettype none

package sirs_pkg;

  localparam int FRAC_BITS_DEF = 47;

  localparam int RATE_W     = 32;
  localparam int STEP_W     = 40;
  localparam int RATE_SHIFT = 28;
  localparam int STEP_SHIFT = 40;
  localparam int TERM_W     = 62;
  localparam int MUL_W      = 64;
  localparam int HALF_W     = 32;
  localparam int ACC_W      = 128;
  localparam int SUM_W      = 66;
  localparam int IN_W       = 8;

  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_LSB = 3;
  localparam int CFG_IDX_W  = CFG_ADDR_W - CFG_IDX_LSB;

  localparam logic [RATE_W-1:0] BETA_RESET  = 32'd134217728;
  localparam logic [RATE_W-1:0] GAMMA_RESET = 32'd134217728;
  localparam logic [RATE_W-1:0] OMEGA_RESET = 32'd2684355;
  localparam logic [STEP_W-1:0] STEP_RESET  = 40'd54975581;
  localparam logic [63:0]       INIT_SUSC_RESET = 64'd139330113471775;

  localparam logic [TERM_W-1:0] TERM_CAP = '1;

  typedef enum logic [2:0] {
    REG_BETA,
    REG_GAMMA,
    REG_OMEGA,
    REG_STEP,
    REG_INIT
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SH_FRAC,
    SH_RATE,
    SH_STEP,
    SH_HALF
  } shift_sel_t;

  typedef struct packed {
    logic             start;
    shift_sel_t       shift;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ISSUE,
    ST_WAIT,
    ST_FINISH
  } state_t;

  // Multiplications of one tick, in issue order.
  typedef enum logic [3:0] {
    OP_SI0,
    OP_INF0,
    OP_REC0,
    OP_LOS0,
    OP_PS,
    OP_PI,
    OP_PR,
    OP_SI1,
    OP_INF1,
    OP_REC1,
    OP_LOS1,
    OP_CS,
    OP_CI,
    OP_CR
  } op_t;

endpackage

`default_nettype wire

// ----- design/sirs_cfg.sv -----
// APB-style register file of the SIRS Heun step block: rates, step size
// and starting susceptible fraction. Depends on sirs_pkg.
`default_nettype none

module sirs_cfg #(
  parameter int FRAC_BITS = sirs_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sirs_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [sirs_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [sirs_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic [sirs_pkg::RATE_W-1:0]      beta,
  output logic [sirs_pkg::RATE_W-1:0]      gamma,
  output logic [sirs_pkg::RATE_W-1:0]      omega,
  output logic [sirs_pkg::STEP_W-1:0]      step,
  output logic [FRAC_BITS:0]               init_susc
);
  import sirs_pkg::*;

  localparam int W = FRAC_BITS + 1;

  logic [RATE_W-1:0]    beta_r, gamma_r, omega_r;
  logic [STEP_W-1:0]    step_r;
  logic [W-1:0]         init_r;
  logic [CFG_IDX_W-1:0] idx;
  logic                 wr;

  assign idx    = paddr[CFG_ADDR_W-1:CFG_IDX_LSB];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r  <= BETA_RESET;
      gamma_r <= GAMMA_RESET;
      omega_r <= OMEGA_RESET;
      step_r  <= STEP_RESET;
      init_r  <= INIT_SUSC_RESET[W-1:0];
    end else if (wr) begin
      case (idx)
        REG_BETA:  beta_r  <= pwdata[RATE_W-1:0];
        REG_GAMMA: gamma_r <= pwdata[RATE_W-1:0];
        REG_OMEGA: omega_r <= pwdata[RATE_W-1:0];
        REG_STEP:  step_r  <= pwdata[STEP_W-1:0];
        REG_INIT:  init_r  <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BETA:  prdata = CFG_DATA_W'(beta_r);
      REG_GAMMA: prdata = CFG_DATA_W'(gamma_r);
      REG_OMEGA: prdata = CFG_DATA_W'(omega_r);
      REG_STEP:  prdata = CFG_DATA_W'(step_r);
      REG_INIT:  prdata = CFG_DATA_W'(init_r);
      default:   prdata = '0;
    endcase
  end

  assign beta      = beta_r;
  assign gamma     = gamma_r;
  assign omega     = omega_r;
  assign step      = step_r;
  assign init_susc = init_r;

endmodule

`default_nettype wire

// ----- design/sirs_mul.sv -----
// Shared 64x64 multiplier of the SIRS Heun step block: four 32x32 partial
// products accumulated over cycles, then a scaling shift with saturation.
// Depends on sirs_pkg.
`default_nettype none

module sirs_mul #(
  parameter int FRAC_BITS = sirs_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sirs_pkg::mul_req_t         req,
  output sirs_pkg::mul_stat_t        stat,
  output logic [sirs_pkg::MUL_W-1:0] res
);
  import sirs_pkg::*;

  localparam int         NUM_PP   = 4;
  localparam logic [2:0] LAST_CNT = 3'(NUM_PP + 1);

  logic [MUL_W-1:0]  a_r, b_r;
  shift_sel_t        shift_r;
  logic [ACC_W-1:0]  acc_r;
  logic [MUL_W-1:0]  pp_r;
  logic [1:0]        pp_idx_r;
  logic [2:0]        cnt_r;
  logic              busy_r, done_r;
  logic [MUL_W-1:0]  res_r;

  logic [HALF_W-1:0] a_half, b_half;
  logic [MUL_W-1:0]  pp;
  logic [ACC_W-1:0]  pp_aligned;
  logic [ACC_W-1:0]  scaled;
  logic [MUL_W-1:0]  res_nxt;
  logic              do_mul, do_acc;

  // Partial product order: lo*lo, lo*hi, hi*lo, hi*hi.
  assign a_half = cnt_r[1] ? a_r[MUL_W-1:HALF_W] : a_r[HALF_W-1:0];
  assign b_half = cnt_r[0] ? b_r[MUL_W-1:HALF_W] : b_r[HALF_W-1:0];
  assign pp     = a_half * b_half;

  assign do_mul = busy_r && (cnt_r < 3'(NUM_PP));
  assign do_acc = busy_r && (cnt_r != 3'd0) && (cnt_r != LAST_CNT);

  always_comb begin
    case (pp_idx_r)
      2'd0:    pp_aligned = {{(ACC_W-MUL_W){1'b0}}, pp_r};
      2'd3:    pp_aligned = {pp_r, {(ACC_W-MUL_W){1'b0}}};
      default: pp_aligned = {{(ACC_W-MUL_W-HALF_W){1'b0}}, pp_r, {HALF_W{1'b0}}};
    endcase
  end

  always_comb begin
    case (shift_r)
      SH_FRAC: scaled = acc_r >> FRAC_BITS;
      SH_RATE: scaled = acc_r >> RATE_SHIFT;
      SH_STEP: scaled = acc_r >> STEP_SHIFT;
      SH_HALF: scaled = acc_r >> (STEP_SHIFT + 1);
      default: scaled = acc_r;
    endcase
    // Saturate when the scaled product does not fit in 64 bits.
    res_nxt = (|scaled[ACC_W-1:MUL_W]) ? '1 : scaled[MUL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == LAST_CNT) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r     <= req.a;
      b_r     <= req.b;
      shift_r <= req.shift;
      acc_r   <= '0;
    end else begin
      if (do_mul) begin
        pp_r     <= pp;
        pp_idx_r <= cnt_r[1:0];
      end
      if (do_acc) begin
        acc_r <= acc_r + pp_aligned;
      end
      if (busy_r && cnt_r == LAST_CNT) begin
        res_r <= res_nxt;
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign res       = res_r;

endmodule

`default_nettype wire

// ----- design/sirs_ode_heun_step.sv -----
// SIRS epidemic compartment model, one Heun integration tick per stepping item.
// The block holds the susceptible, infected and recovered fractions (unsigned
// Q1.FRAC_BITS, always kept in [0, 1]). An item with restart set reloads them
// from the initial_susceptible register (clamped to one), its complement and
// zero; any other item takes an Euler predictor step and then the trapezoid
// corrector x + delta/2*(f(x) + f(x_pred)). With report set, one result item
// carries the three fractions after the item. A stepping item holds in_tready
// low from acceptance until its tick is done, so no new item is taken before
// the last is through; a restart item only passes through the closing state.
// A tick is set by fourteen 64-bit multiplications that run one after the other
// through a single 32x32 multiplier (issue, four partial products, accumulate
// and scaling each), derivative sums formed before each scaling multiplication
// and one closing state. A reported result sits in an output register; the next
// item is accepted while it waits, and a reporting item only holds at its end
// if the previous result has still not been taken. Configuration is written
// through the APB-style port, register i at byte address 8*i, by the user only
// while the block is idle; the block itself does not enforce this.
// Depends on sirs_pkg, sirs_cfg, sirs_mul and assert_macros.svh.
`default_nettype none

module sirs_ode_heun_step #(
  parameter int FRAC_BITS = sirs_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input item
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [sirs_pkg::IN_W-1:0]             in_tdata,   // [0] restart, [1] report
  // result item
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // susceptible, infected, recovered from the lowest bit up, zero padded
  output logic [((3*(FRAC_BITS+1)+7)/8)*8-1:0]  out_tdata,
  // configuration
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [sirs_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  logic [sirs_pkg::CFG_DATA_W-1:0]       cfg_pwdata,
  output logic [sirs_pkg::CFG_DATA_W-1:0]       cfg_prdata,
  output logic                                  cfg_pready
);
  import sirs_pkg::*;
  `include "assert_macros.svh"

  localparam int         W     = FRAC_BITS + 1;
  localparam int         OUT_W = ((3 * W + 7) / 8) * 8;
  localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [W-1:0] INIT_RST = INIT_SUSC_RESET[W-1:0];
  localparam logic [W-1:0] S_RST = (INIT_RST > ONE) ? ONE : INIT_RST;
  localparam logic [W-1:0] I_RST = ONE - S_RST;

  // configuration values
  logic [RATE_W-1:0] beta, gamma, omega;
  logic [STEP_W-1:0] step;
  logic [W-1:0]      init_susc;

  // shared multiplier
  mul_req_t          mul_req;
  mul_stat_t         mul_stat;
  logic [MUL_W-1:0]  mul_res;

  // sequencer and state
  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic              rep_r, rep_nxt;
  logic [W-1:0]      s_r, i_r, r_r, s_nxt, i_nxt, r_nxt;
  logic [W-1:0]      sp_r, ip_r, rp_r, sp_nxt, ip_nxt, rp_nxt;
  logic [MUL_W-1:0]  si_r, si_nxt;
  logic [TERM_W-1:0] inf0_r, rec0_r, los0_r, inf1_r, rec1_r, los1_r;
  logic [TERM_W-1:0] inf0_nxt, rec0_nxt, los0_nxt, inf1_nxt, rec1_nxt, los1_nxt;
  logic [MUL_W-1:0]  f_r, f_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;

  // datapath helpers
  logic [W-1:0]      x_sel, s0;
  logic [TERM_W-1:0] pos0, neg0, pos1, neg1, term_sat;
  logic              corr;
  logic [MUL_W-1:0]  pos_sum, neg_sum, f_calc, f_mag;
  logic [SUM_W-1:0]  x_ext, res_ext, one_ext, upd_sum;
  logic [W-1:0]      x_upd;

  sirs_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (cfg_psel),
    .penable   (cfg_penable),
    .pwrite    (cfg_pwrite),
    .paddr     (cfg_paddr),
    .pwdata    (cfg_pwdata),
    .prdata    (cfg_prdata),
    .pready    (cfg_pready),
    .beta      (beta),
    .gamma     (gamma),
    .omega     (omega),
    .step      (step),
    .init_susc (init_susc)
  );

  sirs_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .stat  (mul_stat),
    .res   (mul_res)
  );

  // Pick the compartment that the current scaling op works on. The derivative
  // of each compartment is one term it gains minus one term it loses:
  // susceptible gains loss-of-immunity and loses infection, infected gains
  // infection and loses recovery, recovered gains recovery and loses immunity.
  always_comb begin
    case (op_r)
      OP_PI, OP_CI: begin
        x_sel = i_r;
        pos0 = inf0_r; neg0 = rec0_r; pos1 = inf1_r; neg1 = rec1_r;
      end
      OP_PR, OP_CR: begin
        x_sel = r_r;
        pos0 = rec0_r; neg0 = los0_r; pos1 = rec1_r; neg1 = los1_r;
      end
      default: begin
        x_sel = s_r;
        pos0 = los0_r; neg0 = inf0_r; pos1 = los1_r; neg1 = inf1_r;
      end
    endcase
  end

  assign corr = (op_r == OP_CS) || (op_r == OP_CI) || (op_r == OP_CR);

  // Predictor uses f(x); corrector uses f(x) + f(x_pred).
  assign pos_sum = {2'b00, pos0} + (corr ? {2'b00, pos1} : '0);
  assign neg_sum = {2'b00, neg0} + (corr ? {2'b00, neg1} : '0);
  assign f_calc  = pos_sum - neg_sum;
  assign f_mag   = f_r[MUL_W-1] ? (~f_r + MUL_W'(1)) : f_r;

  // Rate terms are capped below 2^62.
  assign term_sat = (|mul_res[MUL_W-1:TERM_W]) ? TERM_CAP : mul_res[TERM_W-1:0];

  // Apply the sign of f to delta*|f| and clamp the new fraction to [0, 1].
  assign x_ext   = {{(SUM_W-W){1'b0}}, x_sel};
  assign res_ext = {2'b00, mul_res};
  assign one_ext = {{(SUM_W-W){1'b0}}, ONE};
  assign upd_sum = f_r[MUL_W-1] ? (x_ext - res_ext) : (x_ext + res_ext);

  always_comb begin
    if (upd_sum[SUM_W-1]) begin
      x_upd = '0;
    end else if (upd_sum > one_ext) begin
      x_upd = ONE;
    end else begin
      x_upd = upd_sum[W-1:0];
    end
  end

  assign s0 = (init_susc > ONE) ? ONE : init_susc;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    rep_nxt       = rep_r;
    s_nxt         = s_r;
    i_nxt         = i_r;
    r_nxt         = r_r;
    sp_nxt        = sp_r;
    ip_nxt        = ip_r;
    rp_nxt        = rp_r;
    si_nxt        = si_r;
    inf0_nxt      = inf0_r;
    rec0_nxt      = rec0_r;
    los0_nxt      = los0_r;
    inf1_nxt      = inf1_r;
    rec1_nxt      = rec1_r;
    los1_nxt      = los1_r;
    f_nxt         = f_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mul_req       = '0;
    mul_req.shift = SH_FRAC;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          rep_nxt = in_tdata[1];
          if (in_tdata[0]) begin
            s_nxt     = s0;
            i_nxt     = ONE - s0;
            r_nxt     = '0;
            state_nxt = ST_FINISH;
          end else begin
            op_nxt    = OP_SI0;
            state_nxt = ST_ISSUE;
          end
        end
      end

      ST_PREP: begin
        f_nxt     = f_calc;
        state_nxt = ST_ISSUE;
      end

      ST_ISSUE: begin
        mul_req.start = 1'b1;
        case (op_r)
          OP_SI0: begin
            mul_req.a = {{(MUL_W-W){1'b0}}, s_r};
            mul_req.b = {{(MUL_W-W){1'b0}}, i_r};
            mul_req.shift = SH_FRAC;
          end
          OP_SI1: begin
            mul_req.a = {{(MUL_W-W){1'b0}}, sp_r};
            mul_req.b = {{(MUL_W-W){1'b0}}, ip_r};
            mul_req.shift = SH_FRAC;
          end
          OP_INF0, OP_INF1: begin
            mul_req.a = {{(MUL_W-RATE_W){1'b0}}, beta};
            mul_req.b = si_r;
            mul_req.shift = SH_RATE;
          end
          OP_REC0: begin
            mul_req.a = {{(MUL_W-RATE_W){1'b0}}, gamma};
            mul_req.b = {{(MUL_W-W){1'b0}}, i_r};
            mul_req.shift = SH_RATE;
          end
          OP_REC1: begin
            mul_req.a = {{(MUL_W-RATE_W){1'b0}}, gamma};
            mul_req.b = {{(MUL_W-W){1'b0}}, ip_r};
            mul_req.shift = SH_RATE;
          end
          OP_LOS0: begin
            mul_req.a = {{(MUL_W-RATE_W){1'b0}}, omega};
            mul_req.b = {{(MUL_W-W){1'b0}}, r_r};
            mul_req.shift = SH_RATE;
          end
          OP_LOS1: begin
            mul_req.a = {{(MUL_W-RATE_W){1'b0}}, omega};
            mul_req.b = {{(MUL_W-W){1'b0}}, rp_r};
            mul_req.shift = SH_RATE;
          end
          OP_PS, OP_PI, OP_PR: begin
            mul_req.a = {{(MUL_W-STEP_W){1'b0}}, step};
            mul_req.b = f_mag;
            mul_req.shift = SH_STEP;
          end
          default: begin
            // corrector: delta/2 * |f(x) + f(x_pred)|
            mul_req.a = {{(MUL_W-STEP_W){1'b0}}, step};
            mul_req.b = f_mag;
            mul_req.shift = SH_HALF;
          end
        endcase
        state_nxt = ST_WAIT;
      end

      ST_WAIT: begin
        if (mul_stat.done) begin
          case (op_r)
            OP_SI0, OP_SI1: si_nxt = mul_res;
            OP_INF0: inf0_nxt = term_sat;
            OP_REC0: rec0_nxt = term_sat;
            OP_LOS0: los0_nxt = term_sat;
            OP_INF1: inf1_nxt = term_sat;
            OP_REC1: rec1_nxt = term_sat;
            OP_LOS1: los1_nxt = term_sat;
            OP_PS:   sp_nxt   = x_upd;
            OP_PI:   ip_nxt   = x_upd;
            OP_PR:   rp_nxt   = x_upd;
            OP_CS:   s_nxt    = x_upd;
            OP_CI:   i_nxt    = x_upd;
            OP_CR:   r_nxt    = x_upd;
            default: ;
          endcase
          if (op_r == OP_CR) begin
            state_nxt = ST_FINISH;
          end else begin
            op_nxt = op_t'(op_r + 4'd1);
            if (op_nxt == OP_PS || op_nxt == OP_PI || op_nxt == OP_PR ||
                op_nxt == OP_CS || op_nxt == OP_CI || op_nxt == OP_CR) begin
              state_nxt = ST_PREP;
            end else begin
              state_nxt = ST_ISSUE;
            end
          end
        end
      end

      ST_FINISH: begin
        // Hold here only while an earlier result still waits to be taken.
        if (!rep_r) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_W'({r_r, i_r, s_r});
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      s_r         <= S_RST;
      i_r         <= I_RST;
      r_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      s_r         <= s_nxt;
      i_r         <= i_nxt;
      r_r         <= r_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    rep_r      <= rep_nxt;
    sp_r       <= sp_nxt;
    ip_r       <= ip_nxt;
    rp_r       <= rp_nxt;
    si_r       <= si_nxt;
    inf0_r     <= inf0_nxt;
    rec0_r     <= rec0_nxt;
    los0_r     <= los0_nxt;
    inf1_r     <= inf1_nxt;
    rec1_r     <= rec1_nxt;
    los1_r     <= los1_nxt;
    f_r        <= f_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `ASSERT_ALWAYS(a_frac_bounded, clk, rst_n, (s_r <= ONE) && (i_r <= ONE) && (r_r <= ONE), "fraction above one")
  `ASSERT_IMPL(a_start_when_free, clk, rst_n, mul_req.start, !mul_stat.busy && !mul_stat.done, "multiplier restarted while in use")
  `ASSERT_IMPL(a_done_in_wait, clk, rst_n, mul_stat.done, state_r == ST_WAIT, "multiplier result arrived outside wait")
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready, "item accepted while a tick runs")
  `ASSERT_NEXT(a_result_from_finish, clk, rst_n, !out_tvalid && (state_r != ST_FINISH), !out_tvalid, "result raised outside finish")

endmodule

`default_nettype wire

// ----- tb/sirs_ode_heun_checker.sv -----
// Result checker for the SIRS Heun step block: mirrors the configuration
// registers from the APB-style port, predicts each reported set of fractions
// and compares it with the result channel. Depends on sirs_pkg.
module sirs_ode_heun_checker #(
  parameter int FRAC_BITS = sirs_pkg::FRAC_BITS_DEF,
  parameter int OUT_W     = ((3*(FRAC_BITS+1)+7)/8)*8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [sirs_pkg::IN_W-1:0]         in_tdata,    // [0] restart, [1] report
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [OUT_W-1:0]                  out_tdata,   // susceptible, infected, recovered
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic                              cfg_pready,
  input  logic [sirs_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [sirs_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output int                                fail_count,
  output int                                pending,
  output int                                items_seen,
  output int                                restarts_seen,
  output int                                results_seen
);
  import sirs_pkg::*;

  localparam int          FW        = FRAC_BITS + 1;
  localparam logic [63:0] ONE       = 64'd1 << FRAC_BITS;
  localparam logic [63:0] FRAC_MASK = (ONE << 1) - 64'd1;

  typedef struct packed {
    logic [FW-1:0] rec;
    logic [FW-1:0] infc;
    logic [FW-1:0] susc;
  } frac_set_t;

  logic [RATE_W-1:0] beta_rate, gamma_rate, omega_rate;
  logic [STEP_W-1:0] step_delta;
  logic [63:0]       init_susc;
  logic [63:0]       s_frac, i_frac, r_frac;
  frac_set_t         expected_fracs[$];
  int                failures, accepted, restarts, checked;

  // (a*b) >> sh, saturated to 64 bits
  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] full;
    full = ({64'd0, a} * {64'd0, b}) >> sh;
    if (full[127:64] != '0) return '1;
    return full[63:0];
  endfunction

  function automatic longint rate_term(logic [RATE_W-1:0] rate, logic [63:0] x);
    logic [63:0] t;
    t = mul_shift({32'd0, rate}, x, RATE_SHIFT);
    if (t > {2'b00, TERM_CAP}) t = {2'b00, TERM_CAP};
    return longint'(t);
  endfunction

  // delta * f on the magnitude, truncated toward zero, sign put back
  function automatic longint step_term(longint f, int sh);
    logic [63:0] mag, p;
    mag = (f < 0) ? 64'(-f) : 64'(f);
    p = mul_shift({24'd0, step_delta}, mag, sh);
    return (f < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic [63:0] clamp_frac(longint v);
    if (v < 0) return 64'd0;
    if (v > longint'(ONE)) return ONE;
    return 64'(v);
  endfunction

  function automatic void slopes(input logic [63:0] s, i, r,
                                 output longint fs, fi, fr);
    longint infect, recover, loss;
    infect  = rate_term(beta_rate, mul_shift(s, i, FRAC_BITS));
    recover = rate_term(gamma_rate, i);
    loss    = rate_term(omega_rate, r);
    fs = loss - infect;
    fi = infect - recover;
    fr = recover - loss;
  endfunction

  function automatic void reload_fracs();
    s_frac = (init_susc > ONE) ? ONE : init_susc;
    i_frac = ONE - s_frac;
    r_frac = 64'd0;
  endfunction

  // Euler predictor, then the trapezoid corrector with both slopes
  function automatic void heun_tick();
    longint      fs0, fi0, fr0, fs1, fi1, fr1;
    logic [63:0] sp, ip, rp;
    slopes(s_frac, i_frac, r_frac, fs0, fi0, fr0);
    sp = clamp_frac(longint'(s_frac) + step_term(fs0, STEP_SHIFT));
    ip = clamp_frac(longint'(i_frac) + step_term(fi0, STEP_SHIFT));
    rp = clamp_frac(longint'(r_frac) + step_term(fr0, STEP_SHIFT));
    slopes(sp, ip, rp, fs1, fi1, fr1);
    s_frac = clamp_frac(longint'(s_frac) + step_term(fs0 + fs1, STEP_SHIFT + 1));
    i_frac = clamp_frac(longint'(i_frac) + step_term(fi0 + fi1, STEP_SHIFT + 1));
    r_frac = clamp_frac(longint'(r_frac) + step_term(fr0 + fr1, STEP_SHIFT + 1));
  endfunction

  always @(posedge clk) begin
    frac_set_t got, want;
    if (!rst_n) begin
      beta_rate  = BETA_RESET;
      gamma_rate = GAMMA_RESET;
      omega_rate = OMEGA_RESET;
      step_delta = STEP_RESET;
      init_susc  = INIT_SUSC_RESET & FRAC_MASK;
      reload_fracs();
      expected_fracs.delete();
    end else begin
      // results first: nothing accepted at this edge can be reported at it
      if (out_tvalid && out_tready) begin
        checked++;
        got = out_tdata[3*FW-1:0];
        if (expected_fracs.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t checker: unexpected result s=%h i=%h r=%h",
                     $time, got.susc, got.infc, got.rec);
        end else begin
          want = expected_fracs.pop_front();
          if (got.susc !== want.susc || got.infc !== want.infc || got.rec !== want.rec) begin
            failures++;
            if (failures <= 10)
              $display("%0t checker: result %0d expected s=%h i=%h r=%h, got s=%h i=%h r=%h",
                       $time, checked, want.susc, want.infc, want.rec,
                       got.susc, got.infc, got.rec);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        accepted++;
        if (in_tdata[0]) begin
          restarts++;
          reload_fracs();
        end else begin
          heun_tick();
        end
        if (in_tdata[1]) begin
          want.susc = s_frac[FW-1:0];
          want.infc = i_frac[FW-1:0];
          want.rec  = r_frac[FW-1:0];
          expected_fracs.push_back(want);
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CFG_ADDR_W-1:CFG_IDX_LSB])
          REG_BETA:  beta_rate  = cfg_pwdata[RATE_W-1:0];
          REG_GAMMA: gamma_rate = cfg_pwdata[RATE_W-1:0];
          REG_OMEGA: omega_rate = cfg_pwdata[RATE_W-1:0];
          REG_STEP:  step_delta = cfg_pwdata[STEP_W-1:0];
          REG_INIT:  init_susc  = cfg_pwdata & FRAC_MASK;
          default: ;
        endcase
      end
    end
    fail_count    <= failures;
    pending       <= expected_fracs.size();
    items_seen    <= accepted;
    restarts_seen <= restarts;
    results_seen  <= checked;
  end

endmodule

// ----- tb/sirs_ode_heun_step_tb.sv -----
// Top of the SIRS Heun step testbench: clock, reset, item and register
// stimulus, receiver stalls and the verdict. Depends on sirs_pkg, the block
// and sirs_ode_heun_checker, which does all prediction and comparison.
module sirs_ode_heun_step_tb;
  import sirs_pkg::*;

  localparam int FRAC_BITS   = FRAC_BITS_DEF;
  localparam int OUT_W       = ((3*(FRAC_BITS+1)+7)/8)*8;
  localparam int TICK_CYCLES = 120;   // allowance for a last unreported tick in settle()
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 110;

  localparam logic [63:0] ONE       = 64'd1 << FRAC_BITS;
  localparam logic [63:0] RATE_MAX  = 64'hFFFF_FFFF;
  localparam logic [63:0] STEP_MAX  = 64'hFF_FFFF_FFFF;
  localparam logic [63:0] FRAC_FULL = (ONE << 1) - 64'd1;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata;     // [0] restart, [1] report
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_W-1:0]      out_tdata;    // susceptible, infected, recovered from bit 0 up
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int fail_count, pending, items_seen, restarts_seen, results_seen;
  int send_gap_pct = 0;   // chance that the sender idles before an item
  int stall_pct    = 0;   // share of cycles in which the receiver stalls
  int ready_hold   = 0;

  sirs_ode_heun_step #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  sirs_ode_heun_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_pready    (cfg_pready),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .items_seen    (items_seen),
    .restarts_seen (restarts_seen),
    .results_seen  (results_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: stall on about stall_pct cycles of a hundred; now and then
  // hold a long stall so that a finished tick waits while its
  // predecessor's result is still in the output register.
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else if (stall_pct != 0 && $urandom_range(499) == 0) begin
      out_tready <= 1'b0;
      ready_hold = $urandom_range(250, 130);
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Two-phase register write: setup cycle, then access until pready.
  // Then idle with psel low so back-to-back writes never re-raise psel
  // in the step that drops it.
  task automatic cfg_write(input int idx, input logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(idx << CFG_IDX_LSB);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one item; valid stays high after the handshake so that a
  // following item without a gap goes out back to back.
  task automatic send_item(input logic restart, input logic report);
    int              gap;
    logic [IN_W-1:0] word;
    gap = 0;
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct)
      gap = ($urandom_range(3) == 0) ? $urandom_range(140, 20) : $urandom_range(4, 1);
    word    = '0;
    word[0] = restart;
    word[1] = report;
    if (gap != 0) begin
      // drop valid and put noise on the data lines while idle
      in_tvalid <= 1'b0;
      in_tdata  <= IN_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop valid, wait for every expected result, then give a last
  // unreported tick time to finish before registers may change.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TICK_CYCLES + 10) @(posedge clk);
  endtask

  // Rates: zero, full scale, anything, or the useful range up to 4.0.
  function automatic logic [63:0] pick_rate();
    case ($urandom_range(5))
      0:       return 64'd0;
      1:       return RATE_MAX;
      2:       return {32'd0, $urandom};
      default: return {32'd0, $urandom_range(32'h4000_0000)};
    endcase
  endfunction

  // Step: full scale, zero, anything, or below 1/16 so the run stays smooth.
  function automatic logic [63:0] pick_step();
    case ($urandom_range(5))
      0:       return STEP_MAX;
      1:       return 64'd0;
      2:       return {$urandom, $urandom} & STEP_MAX;
      default: return {28'd0, 4'($urandom_range(15)), $urandom};
    endcase
  endfunction

  // Initial susceptible: one, zero, above one (clamped on reload), any.
  function automatic logic [63:0] pick_init();
    case ($urandom_range(5))
      0:       return ONE;
      1:       return 64'd0;
      2:       return ONE | ({$urandom, $urandom} & (ONE - 64'd1));
      3:       return {$urandom, $urandom} & FRAC_FULL;
      default: return {$urandom, $urandom} % (ONE + 64'd1);
    endcase
  endfunction

  initial begin
    int ph, n, k;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    out_tready  <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: step from the reset fractions, restart with and without
    // report, back-to-back items.
    send_item(1'b0, 1'b1);
    send_item(1'b0, 1'b0);
    send_item(1'b0, 1'b1);
    send_item(1'b1, 1'b1);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b1);

    // Initial fraction above one: reload clamps susceptible to one.
    settle();
    cfg_write(REG_INIT, FRAC_FULL);
    send_item(1'b1, 1'b1);
    send_item(1'b0, 1'b1);

    // All infected at the start.
    settle();
    cfg_write(REG_INIT, 64'd0);
    send_item(1'b1, 1'b1);
    send_item(1'b0, 1'b1);

    // Full-scale infection and immunity loss, no recovery, largest step:
    // the predictor and corrector saturate at both ends.
    settle();
    cfg_write(REG_BETA, RATE_MAX);
    cfg_write(REG_GAMMA, 64'd0);
    cfg_write(REG_OMEGA, RATE_MAX);
    cfg_write(REG_STEP, STEP_MAX);
    cfg_write(REG_INIT, ONE >> 1);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b1);
    send_item(1'b0, 1'b1);
    send_item(1'b0, 1'b1);

    // Full-scale recovery only; plain SIR with omega at zero.
    settle();
    cfg_write(REG_BETA, 64'd0);
    cfg_write(REG_GAMMA, RATE_MAX);
    cfg_write(REG_OMEGA, 64'd0);
    send_item(1'b0, 1'b1);
    send_item(1'b0, 1'b1);

    // Zero step: the fractions must not move.
    settle();
    cfg_write(REG_BETA, RATE_MAX);
    cfg_write(REG_STEP, 64'd0);
    send_item(1'b0, 1'b1);

    // Writes to unused indexes are ignored by the block.
    settle();
    for (k = REG_INIT + 1; k < (1 << CFG_IDX_W); k++)
      cfg_write(k, {$urandom, $urandom});
    send_item(1'b0, 1'b1);

    // Random part: two register settings per idling mix, each opened by a
    // reported restart. Mid-phase, hold the sender until all results are in.
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph / 2)
        0:       begin send_gap_pct = 0;  stall_pct = 0;  end
        1:       begin send_gap_pct = 57; stall_pct = 0;  end
        2:       begin send_gap_pct = 0;  stall_pct = 57; end
        default: begin send_gap_pct = 18; stall_pct = 18; end
      endcase
      settle();
      cfg_write(REG_BETA, pick_rate());
      cfg_write(REG_GAMMA, pick_rate());
      cfg_write(REG_OMEGA, pick_rate());
      cfg_write(REG_STEP, pick_step());
      cfg_write(REG_INIT, pick_init());
      send_item(1'b1, 1'b1);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) settle();
        send_item($urandom_range(99) < 6, $urandom_range(99) < 65);
      end
    end

    settle();
    $display("covered %0d items (%0d restarts), %0d results checked, %0d random settings",
             items_seen, restarts_seen, results_seen, PHASES);
    $display("idling mixes: none, sender only, receiver only, both");
    if (fail_count == 0 && pending == 0) begin
      $display("sirs_ode_heun_step_tb: done, clean");
    end else begin
      $display("sirs_ode_heun_step_tb: done, errors");
    end
    $finish;
  end

  // Hard stop, several times the slowest legal run.
  initial begin
    #50_000_000;
    $display("sirs_ode_heun_step_tb: done, errors");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/sirs_pkg.sv
design/sirs_cfg.sv
design/sirs_mul.sv
design/sirs_ode_heun_step.sv
tb/sirs_ode_heun_checker.sv
tb/sirs_ode_heun_step_tb.sv
